@@ rtl/rpdt_pkg.sv @@
// Shared constants and types for the radius point dedup table.
`timescale 1ns / 1ps
package rpdt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_WIDTH = 16;
  localparam int CLASS_COUNT = 2;
  localparam int CLS_W       = 1;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = CLS_W + IDX_W;
  localparam int RAM_DEPTH = CLASS_COUNT << IDX_W;
  localparam int POINT_W = 3 * COORD_WIDTH;
  localparam int IN_DATA_W = ((POINT_W + 7) / 8) * 8;

  localparam int SQ_W  = 2 * COORD_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  localparam int RAD_W = 32;
  localparam int CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam int ID_W  = 32;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 32'd65536;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } cmp_res_t;

endpackage

@@ rtl/rpdt_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rpdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rpdt_dist.sv @@
// Three-stage squared distance compare of a stored entry against the query point.
`timescale 1ns / 1ps
module rpdt_dist import rpdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  point_t           query,
  input  point_t           entry,
  input  logic [RAD_W-1:0] radius,
  output cmp_res_t         res
);

  logic [2:0][COORD_WIDTH-1:0] mag_r, mag_nxt;
  logic [2:0][SQ_W-1:0]        sq_r;
  logic                        v1_r, v2_r, v3_r;
  logic                        hit_r;
  logic [SUM_W-1:0]            sum;
  logic signed [COORD_WIDTH:0] diff [3];

  always_comb begin
    diff[0] = {query.x[COORD_WIDTH-1], query.x} - {entry.x[COORD_WIDTH-1], entry.x};
    diff[1] = {query.y[COORD_WIDTH-1], query.y} - {entry.y[COORD_WIDTH-1], entry.y};
    diff[2] = {query.z[COORD_WIDTH-1], query.z} - {entry.z[COORD_WIDTH-1], entry.z};
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = diff[k][COORD_WIDTH] ? COORD_WIDTH'(-diff[k])
                                        : diff[k][COORD_WIDTH-1:0];
    end
  end

  assign sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= SQ_W'(mag_r[k]) * SQ_W'(mag_r[k]);
    end
    hit_r <= CMP_W'(sum) <= CMP_W'(radius);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.vld = v3_r;
  assign res.hit = hit_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##3 res.vld) else $error("compare result lost");

endmodule

@@ rtl/radius_point_dedup_table.sv @@
// Top level: per-class point table scan and near-duplicate decision.
// One point at a time: a new point is accepted only after the last one finishes; the scan
// reads the point memory one entry per cycle; a result still held stalls the next finish.
// Reset (rst_n, synchronous): class counts and marker counter cleared, radius 1 m^2.
// Point memory is not cleared; only entries below the class count are ever read.
`timescale 1ns / 1ps
module radius_point_dedup_table import rpdt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // x_coord, y_coord, z_coord
  input  logic                 in_tuser,   // point_class
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ID_W-1:0]      out_tdata,  // assigned_id
  output logic [1:0]           out_tuser,  // is_new, was_stored
  input  logic                 cfg_we,
  input  logic [RAD_W-1:0]     cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RAD_W-1:0] radius_r;
  logic [ID_W-1:0]  marker_r;
  logic [CNT_W-1:0] count_r [CLASS_COUNT];
  logic             cls_r;
  point_t           point_r;
  logic [CNT_W-1:0] n_r, iss_r, done_r;
  logic             dup_r;
  logic             rd_vld_r;
  logic             out_vld_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_new_r, out_stored_r;

  logic             in_acc, rd_en, fin_go, room, mem_we;
  point_t           entry;
  cmp_res_t         cmp;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_en     = (state_r == ST_SCAN) && (iss_r != n_r);
  assign fin_go    = (state_r == ST_FINISH) && (!out_vld_r || out_tready);
  assign room      = n_r < CNT_W'(TABLE_DEPTH);
  assign mem_we    = fin_go && !dup_r && room;

  // Reads and the single write of an item never overlap, so no forwarding.
  rpdt_ram #(
    .WIDTH (POINT_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({cls_r, n_r[IDX_W-1:0]}),
    .wdata (point_r),
    .re    (rd_en),
    .raddr ({cls_r, iss_r[IDX_W-1:0]}),
    .rdata (entry)
  );

  rpdt_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r),
    .query  (point_r),
    .entry  (entry),
    .radius (radius_r),
    .res    (cmp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (done_r == n_r && iss_r == n_r) state_nxt = ST_FINISH;
      ST_FINISH: if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cls_r   <= in_tuser;
      point_r <= point_t'(in_tdata[POINT_W-1:0]);
    end
    if (fin_go) begin
      out_new_r    <= !dup_r;
      out_stored_r <= !dup_r && room;
      out_id_r     <= dup_r ? marker_r : marker_r + ID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radius_r  <= RADIUS_RESET;
      marker_r  <= '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        count_r[k] <= '0;
      end
      n_r       <= '0;
      iss_r     <= '0;
      done_r    <= '0;
      dup_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (in_acc) begin
        n_r    <= count_r[in_tuser];
        iss_r  <= '0;
        done_r <= '0;
        dup_r  <= 1'b0;
      end
      if (rd_en) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      if (cmp.vld) begin
        done_r <= done_r + CNT_W'(1);
        if (cmp.hit) begin
          dup_r <= 1'b1;
        end
      end
      if (fin_go) begin
        out_vld_r <= 1'b1;
        if (!dup_r) begin
          marker_r <= marker_r + ID_W'(1);
        end
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (mem_we) begin
        count_r[cls_r] <= n_r + CNT_W'(1);
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = {out_stored_r, out_new_r};

  a_rd_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> iss_r < n_r) else $error("read beyond class count");

  a_done_le_iss: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= iss_r) else $error("more compares than reads");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= CNT_W'(TABLE_DEPTH) && count_r[1] <= CNT_W'(TABLE_DEPTH))
    else $error("class count over depth");

  a_store_flag: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_vld_r && out_stored_r && out_new_r)
    else $error("store without was_stored");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the radius point dedup table: class scoreboard plus stream drivers.
`timescale 1ns / 1ps
module tb;
  import rpdt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 272;

  typedef struct packed {
    logic            is_new;
    logic            was_stored;
    logic [ID_W-1:0] id;
  } verdict_t;

  class dedup_scoreboard;
    point_t          pts [CLASS_COUNT][TABLE_DEPTH];
    int unsigned     fill [CLASS_COUNT];
    logic [ID_W-1:0] marker;
    logic [RAD_W-1:0] radius;
    verdict_t        verdict_q [$];
    int              errors;

    function new();
      for (int c = 0; c < CLASS_COUNT; c++) fill[c] = 0;
      marker = '0;
      radius = RADIUS_RESET;
      errors = 0;
    endfunction

    function longint unsigned dist_sq(point_t a, point_t b);
      longint dx, dy, dz;
      dx = longint'($signed(a.x)) - longint'($signed(b.x));
      dy = longint'($signed(a.y)) - longint'($signed(b.y));
      dz = longint'($signed(a.z)) - longint'($signed(b.z));
      return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Predicts the verdict for an accepted point and updates the shadow tables.
    function void note_point(logic cls, point_t p);
      verdict_t    v;
      bit          dup;
      int unsigned n;
      n = fill[cls];
      dup = 1'b0;
      for (int i = 0; i < n && !dup; i++) begin
        if (dist_sq(p, pts[cls][i]) <= longint'(radius)) dup = 1'b1;
      end
      if (dup) begin
        v.is_new     = 1'b0;
        v.was_stored = 1'b0;
      end else begin
        marker       = marker + ID_W'(1);
        v.is_new     = 1'b1;
        v.was_stored = (n < TABLE_DEPTH);
        if (n < TABLE_DEPTH) begin
          pts[cls][n] = p;
          fill[cls]   = n + 1;
        end
      end
      v.id = marker;
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void check_verdict(logic [ID_W-1:0] id, logic [1:0] flags);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("unexpected result item: id %0d flags %b", id, flags);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (flags[0] !== v.is_new) begin
        $error("is_new: expected %0b, got %0b", v.is_new, flags[0]);
        errors++;
      end
      if (flags[1] !== v.was_stored) begin
        $error("was_stored: expected %0b, got %0b", v.was_stored, flags[1]);
        errors++;
      end
      if (id !== v.id) begin
        $error("assigned_id: expected %0d, got %0d", v.id, id);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // x_coord, y_coord, z_coord
  logic                 in_tuser = 1'b0; // point_class
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [ID_W-1:0]      out_tdata;       // assigned_id
  logic [1:0]           out_tuser;       // is_new, was_stored
  logic                 cfg_we = 1'b0;
  logic [RAD_W-1:0]     cfg_wdata = '0;

  dedup_scoreboard sb;
  bit              in_no_idle = 1'b0;
  bit              out_no_idle = 1'b0;
  int              idle_cycles = 0;

  radius_point_dedup_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic point_t pt3(int x, int y, int z);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    return p;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Up to half near or exact repeats of stored points, the rest extremes and noise.
  function automatic point_t random_point(logic cls);
    point_t base;
    point_t p;
    int     mode;
    int     amp;
    mode = $urandom_range(0, 99);
    if (mode < 50 && sb.fill[cls] > 0) begin
      base = sb.pts[cls][$urandom_range(0, sb.fill[cls] - 1)];
      if (mode < 12) return base;
      case ($urandom_range(0, 3))
        0: amp = 4;
        1: amp = 64;
        2: amp = 256;
        default: amp = 700;
      endcase
      p.x = base.x + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
      p.y = base.y + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
      p.z = base.z + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
    end else if (mode < 65) begin
      p.x = extreme_coord();
      p.y = extreme_coord();
      p.z = extreme_coord();
    end else begin
      p = POINT_W'({$urandom, $urandom});
    end
    return p;
  endfunction

  task automatic send_point(input logic cls, input point_t p);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= cls;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_point(cls, p);
  endtask

  task automatic set_radius(input logic [RAD_W-1:0] r);
    in_tvalid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.radius = r;
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(posedge clk); while (out_tvalid !== 1'b1);
        end
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_verdict(out_tdata, out_tuser);
    end
  end

  initial begin
    logic [RAD_W-1:0] sweep [6];
    logic             cls;
    sweep[0] = RADIUS_RESET;
    sweep[1] = 32'd400;
    sweep[2] = 32'd1 << 20;
    sweep[3] = '0;
    sweep[4] = '1;
    sweep[5] = $urandom;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radius of one square metre; boundary at exactly 256 in one axis
    send_point(1'b0, pt3(0, 0, 0));
    send_point(1'b0, pt3(256, 0, 0));
    send_point(1'b0, pt3(257, 0, 0));
    send_point(1'b0, pt3(0, -256, 0));
    send_point(1'b1, pt3(0, 0, 0));
    send_point(1'b1, pt3(-32768, -32768, -32768));
    send_point(1'b1, pt3(32767, 32767, 32767));
    send_point(1'b1, pt3(32767, 32767, 32767));
    send_point(1'b0, pt3(148, 148, 148));
    send_point(1'b0, pt3(-148, 148, -149));

    // zero radius: only exact repeats match
    set_radius('0);
    send_point(1'b0, pt3(0, 0, 0));
    send_point(1'b0, pt3(0, 0, 1));
    send_point(1'b1, pt3(-32768, -32768, -32768));
    send_point(1'b1, pt3(-32768, -32768, -32767));

    // full-scale radius
    set_radius('1);
    send_point(1'b0, pt3(-32768, -32768, -32768));
    send_point(1'b1, pt3(32767, -32768, 32767));
    send_point(1'b0, pt3(32767, 32767, 32767));
    send_point(1'b1, pt3(-32768, 32767, -32768));

    for (int ph = 0; ph < 6; ph++) begin
      set_radius(sweep[ph]);
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        cls = 1'($urandom_range(0, 1));
        send_point(cls, random_point(cls));
      end
    end
    in_tvalid <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ radius_point_dedup_table.f @@
rtl/rpdt_pkg.sv
rtl/rpdt_ram.sv
rtl/rpdt_dist.sv
rtl/radius_point_dedup_table.sv
test/tb.sv
